// ===== design/rolling_hash_pattern_matcher_macros.svh =====
// Assertion macros shared by the rolling hash matcher RTL.
`ifndef ROLLING_HASH_PATTERN_MATCHER_MACROS_SVH
`define ROLLING_HASH_PATTERN_MATCHER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RHPM_ASSERT_NOW(label, clk_sig, rst_n_sig, ante, cons) \
	label: assert property (@(posedge clk_sig) disable iff (!(rst_n_sig)) (ante) |-> (cons)) \
		else $error("rolling hash matcher: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define RHPM_ASSERT_NEXT(label, clk_sig, rst_n_sig, ante, cons) \
	label: assert property (@(posedge clk_sig) disable iff (!(rst_n_sig)) (ante) |=> (cons)) \
		else $error("rolling hash matcher: next-cycle check failed");

`endif

// ===== design/rhpm_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and modular arithmetic helpers for the rolling hash matcher.
package rhpm_pkg;

	localparam int HASH_W          = 30;
	localparam int POS_W           = 32;
	localparam int BYTE_W          = 8;
	localparam int LEN_W           = 7;
	localparam int MAX_PATTERN_DEF = 64;

	localparam logic [HASH_W-1:0] HASH_MOD    = 30'd1000000009;
	localparam logic [HASH_W-1:0] HASH_BASE   = 30'd31;
	localparam logic [BYTE_W-1:0] CHAR_OFFSET = 8'd96;

	// base product: 31 * x < 2^35; character product: 8 x 30 bits
	localparam int BASE_W  = HASH_W + 5;
	localparam int BASE_SH = BASE_W - 6;
	localparam int MUL_W   = HASH_W + BYTE_W;
	localparam int MUL_SH  = MUL_W - 8;

	// configuration register indexes
	typedef enum logic {
		REG_PATTERN_HASH   = 1'b0,
		REG_PATTERN_LENGTH = 1'b1
	} reg_index_t;

	// quotient-estimate tables: entry t holds floor(t*2^sh / M) * M
	typedef logic [BASE_W-1:0] base_tab_t [64];
	typedef logic [MUL_W-1:0]  mul_tab_t [256];

	// quotient grows with t, so it is stepped up rather than divided out
	function automatic base_tab_t build_base_tab();
		base_tab_t tab;
		longint    q;
		q = 0;
		for (int t = 0; t < 64; t++) begin
			while ((q + 1) * longint'(HASH_MOD) <= (longint'(t) << BASE_SH)) begin
				q++;
			end
			tab[t] = BASE_W'(q * longint'(HASH_MOD));
		end
		return tab;
	endfunction

	function automatic mul_tab_t build_mul_tab();
		mul_tab_t tab;
		longint   q;
		q = 0;
		for (int t = 0; t < 256; t++) begin
			while ((q + 1) * longint'(HASH_MOD) <= (longint'(t) << MUL_SH)) begin
				q++;
			end
			tab[t] = MUL_W'(q * longint'(HASH_MOD));
		end
		return tab;
	endfunction

	localparam base_tab_t BASE_TAB = build_base_tab();
	localparam mul_tab_t  MUL_TAB  = build_mul_tab();

	// x * 31 mod M for x < M; estimate leaves a remainder below 2M
	function automatic logic [HASH_W-1:0] mul_base_mod(input logic [HASH_W-1:0] x);
		logic [BASE_W-1:0] y;
		logic [BASE_W-1:0] r;
		y = BASE_W'(x) * BASE_W'(HASH_BASE);
		r = y - BASE_TAB[y[BASE_W-1:BASE_SH]];
		if (r >= BASE_W'(HASH_MOD)) begin
			r = r - BASE_W'(HASH_MOD);
		end
		return r[HASH_W-1:0];
	endfunction

endpackage

// ===== design/rhpm_cell.sv =====
`timescale 1ns / 1ps
// One cell of the prefix history chain: holds a prefix hash, passes it on per item.
module rhpm_cell (
	input  logic                        clk,
	input  logic                        shift,
	input  logic [rhpm_pkg::HASH_W-1:0] din,
	output logic [rhpm_pkg::HASH_W-1:0] dout
);

	logic [rhpm_pkg::HASH_W-1:0] hold_q;

	// take the neighbour's value when an item moves through
	always_ff @(posedge clk) begin
		if (shift) begin
			hold_q <= din;
		end
	end

	assign dout = hold_q;

endmodule

// ===== design/rhpm_history.sv =====
`timescale 1ns / 1ps
// Prefix hash history: a chain of cells, cell k holds the prefix from k items back.
module rhpm_history #(
	parameter int DEPTH = rhpm_pkg::MAX_PATTERN_DEF,
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                        clk,
	input  logic                        shift,
	input  logic [rhpm_pkg::HASH_W-1:0] hold_in,
	input  logic [IDX_W-1:0]            tap_sel,
	output logic [rhpm_pkg::HASH_W-1:0] tap_out
);

	logic [rhpm_pkg::HASH_W-1:0] cell_q [DEPTH];

	// cell 0 takes the newest prefix, the others their left neighbour
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			rhpm_cell u_cell (
				.clk  (clk),
				.shift(shift),
				.din  (hold_in),
				.dout (cell_q[i])
			);
		end else begin : g_body
			rhpm_cell u_cell (
				.clk  (clk),
				.shift(shift),
				.din  (cell_q[i-1]),
				.dout (cell_q[i])
			);
		end
	end

	// tap for the window start, picked by pattern length
	assign tap_out = cell_q[tap_sel];

endmodule

// ===== design/rolling_hash_pattern_matcher.sv =====
`timescale 1ns / 1ps
// Top level of the rolling hash pattern matcher.
//
// Takes one text byte per transaction and returns one result per byte: a flag saying whether
// the window of the last pattern_length bytes hashes equal to the loaded pattern hash
// (sum of (byte-96)*31^k mod 1000000009, no character check), and that window's start
// position. text_start on a byte begins a new text. Sustained rate is one byte per clock
// while the output is not stalled; a result passes through registers s1 to s7. The rate is
// set by the x31 modular updates of the power and target registers at the input and by the
// running hash accumulator. Earlier prefix hashes sit in a chain of MAX_PATTERN cells that
// shifts once per item; no clearing pass is needed after reset. A stage stalls only if it holds
// an item and the stage after it stalls, so bytes are accepted behind a waiting result until
// the stages fill. Write pattern_hash and pattern_length only while the block is idle.
`include "rolling_hash_pattern_matcher_macros.svh"
module rolling_hash_pattern_matcher #(
	parameter int MAX_PATTERN = rhpm_pkg::MAX_PATTERN_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [rhpm_pkg::BYTE_W-1:0] s_tdata,   // [7:0] text_byte
	input  logic                        s_tuser,   // [0] text_start
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [rhpm_pkg::POS_W-1:0]  m_tdata,   // [31:0] match_position
	output logic                        m_tuser,   // [0] match_found
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [rhpm_pkg::HASH_W-1:0] cfg_data
);

	localparam int HW  = rhpm_pkg::HASH_W;
	localparam int PW  = rhpm_pkg::POS_W;
	localparam int BW  = rhpm_pkg::BYTE_W;
	localparam int MW  = rhpm_pkg::MUL_W;
	localparam int MSH = rhpm_pkg::MUL_SH;
	localparam int RW  = HW + 2;
	localparam int LW  = ($clog2(MAX_PATTERN + 1) > rhpm_pkg::LEN_W) ?
		$clog2(MAX_PATTERN + 1) : rhpm_pkg::LEN_W;
	localparam int IW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	localparam logic [HW:0]   MOD_X  = {1'b0, rhpm_pkg::HASH_MOD};
	localparam logic [RW-1:0] MOD_R  = RW'(rhpm_pkg::HASH_MOD);
	localparam logic [RW-1:0] MOD2_R = MOD_R << 1;

	// configuration and front state
	logic [HW-1:0]                 phash_q;
	logic [rhpm_pkg::LEN_W-1:0]    len_q;
	logic [HW-1:0]                 pow_q;
	logic [HW-1:0]                 tgt_q;
	logic [PW-1:0]                 cnt_q;
	logic [LW-1:0]                 fill_q;
	logic [HW-1:0]                 acc_q;

	// pipeline valids and stall chain
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;
	logic accept;
	logic load5;

	// front comb
	logic [LW-1:0] len_ext;
	logic [LW-1:0] len_eff;
	logic [IW-1:0] tap_sel;
	logic [HW-1:0] pow_used;
	logic [HW-1:0] tgt_used;
	logic [PW-1:0] cnt_used;
	logic [LW-1:0] fill_used;
	logic [LW-1:0] fill_next;
	logic          in_window;
	logic          neg_in;
	logic [BW-1:0] mag_in;
	logic [PW-1:0] pos_in;
	logic [HW-1:0] cfg_hash;

	// pipeline payload
	logic [BW-1:0] mag_s1;
	logic [HW-1:0] pow_s1;
	logic          neg_s1, neg_s2, neg_s3, neg_s4;
	logic          start_s1, start_s2, start_s3, start_s4;
	logic [HW-1:0] tgt_s1, tgt_s2, tgt_s3, tgt_s4, tgt_s5, tgt_s6;
	logic          win_s1, win_s2, win_s3, win_s4, win_s5, win_s6;
	logic [PW-1:0] pos_s1, pos_s2, pos_s3, pos_s4, pos_s5, pos_s6, pos_s7;
	logic [MW-1:0] prod_s2;
	logic [RW-1:0] red_s3;
	logic [HW-1:0] cp_s4;
	logic [HW-1:0] hnew_s5, hnew_s6;
	logic [HW-1:0] old_s6;
	logic          found_s7;

	// accumulator and window comb
	logic [HW-1:0] hold;
	logic [HW:0]   dsum;
	logic [HW-1:0] hnew;
	logic [HW-1:0] tap_out;
	logic [HW:0]   wdiff;
	logic [HW-1:0] wsum;

	// effective pattern length: zero acts as one, clamp to chain depth
	always_comb begin
		len_ext = LW'(len_q);
		priority if (len_ext == '0) begin
			len_eff = LW'(1);
		end else if (len_ext > LW'(MAX_PATTERN)) begin
			len_eff = LW'(MAX_PATTERN);
		end else begin
			len_eff = len_ext;
		end
	end

	assign tap_sel = IW'(len_eff - LW'(1));

	// stall chain, output register last
	assign rdy7     = !v_s7 || m_tready;
	assign rdy6     = !v_s6 || rdy7;
	assign rdy5     = !v_s5 || rdy6;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign s_tready = rdy1;
	assign accept   = s_tvalid && rdy1;
	assign load5    = rdy5 && v_s4;

	// per-item front values; a new text restarts position, power and target
	always_comb begin
		pow_used  = s_tuser ? HW'(1) : pow_q;
		tgt_used  = s_tuser ? phash_q : tgt_q;
		cnt_used  = s_tuser ? '0 : cnt_q;
		fill_used = s_tuser ? '0 : fill_q;
		fill_next = (fill_used < LW'(MAX_PATTERN)) ? fill_used + LW'(1) : fill_used;
		in_window = fill_next >= len_eff;
		neg_in    = s_tdata < rhpm_pkg::CHAR_OFFSET;
		mag_in    = neg_in ? rhpm_pkg::CHAR_OFFSET - s_tdata : s_tdata - rhpm_pkg::CHAR_OFFSET;
		pos_in    = cnt_used + PW'(1) - PW'(len_eff);
		cfg_hash  = (cfg_data >= rhpm_pkg::HASH_MOD) ? cfg_data - rhpm_pkg::HASH_MOD : cfg_data;
	end

	// running prefix hash: add or subtract the character term
	always_comb begin
		hold = start_s4 ? '0 : acc_q;
		if (neg_s4) begin
			dsum = {1'b0, hold} - {1'b0, cp_s4};
			hnew = dsum[HW] ? HW'(dsum + MOD_X) : dsum[HW-1:0];
		end else begin
			dsum = {1'b0, hold} + {1'b0, cp_s4};
			hnew = (dsum >= MOD_X) ? HW'(dsum - MOD_X) : dsum[HW-1:0];
		end
	end

	// window hash: newest prefix minus prefix at window start
	always_comb begin
		wdiff = {1'b0, hnew_s6} - {1'b0, old_s6};
		wsum  = wdiff[HW] ? HW'(wdiff + MOD_X) : wdiff[HW-1:0];
	end

	// control state, configuration, valids and recurrences
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phash_q <= '0;
			len_q   <= rhpm_pkg::LEN_W'(1);
			pow_q   <= HW'(1);
			tgt_q   <= '0;
			cnt_q   <= '0;
			fill_q  <= '0;
			acc_q   <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			v_s6    <= 1'b0;
			v_s7    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (rhpm_pkg::reg_index_t'(cfg_index))
					rhpm_pkg::REG_PATTERN_HASH: begin
						phash_q <= cfg_hash;
						if (cnt_q == '0) begin
							tgt_q <= cfg_hash;
						end
					end
					rhpm_pkg::REG_PATTERN_LENGTH: begin
						len_q <= cfg_data[rhpm_pkg::LEN_W-1:0];
					end
				endcase
			end
			if (accept) begin
				pow_q  <= rhpm_pkg::mul_base_mod(pow_used);
				tgt_q  <= in_window ? rhpm_pkg::mul_base_mod(tgt_used) : tgt_used;
				cnt_q  <= cnt_used + PW'(1);
				fill_q <= fill_next;
			end
			if (load5) begin
				acc_q <= hnew;
			end
			if (rdy1) begin
				v_s1 <= s_tvalid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (rdy4) begin
				v_s4 <= v_s3;
			end
			if (rdy5) begin
				v_s5 <= v_s4;
			end
			if (rdy6) begin
				v_s6 <= v_s5;
			end
			if (rdy7) begin
				v_s7 <= v_s6;
			end
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		// s1: captured byte term and front values
		if (rdy1) begin
			mag_s1   <= mag_in;
			neg_s1   <= neg_in;
			pow_s1   <= pow_used;
			tgt_s1   <= tgt_used;
			win_s1   <= in_window;
			pos_s1   <= pos_in;
			start_s1 <= s_tuser;
		end
		// s2: character magnitude times power
		if (rdy2) begin
			prod_s2  <= {{HW{1'b0}}, mag_s1} * {{BW{1'b0}}, pow_s1};
			neg_s2   <= neg_s1;
			tgt_s2   <= tgt_s1;
			win_s2   <= win_s1;
			pos_s2   <= pos_s1;
			start_s2 <= start_s1;
		end
		// s3: subtract estimated multiple of M, remainder below 3M
		if (rdy3) begin
			red_s3   <= RW'(prod_s2 - rhpm_pkg::MUL_TAB[prod_s2[MW-1:MSH]]);
			neg_s3   <= neg_s2;
			tgt_s3   <= tgt_s2;
			win_s3   <= win_s2;
			pos_s3   <= pos_s2;
			start_s3 <= start_s2;
		end
		// s4: final correction into [0, M)
		if (rdy4) begin
			if (red_s3 >= MOD2_R) begin
				cp_s4 <= HW'(red_s3 - MOD2_R);
			end else if (red_s3 >= MOD_R) begin
				cp_s4 <= HW'(red_s3 - MOD_R);
			end else begin
				cp_s4 <= red_s3[HW-1:0];
			end
			neg_s4   <= neg_s3;
			tgt_s4   <= tgt_s3;
			win_s4   <= win_s3;
			pos_s4   <= pos_s3;
			start_s4 <= start_s3;
		end
		// s5: accumulated prefix, history chain shifts in the same transaction
		if (rdy5) begin
			hnew_s5 <= hnew;
			tgt_s5  <= tgt_s4;
			win_s5  <= win_s4;
			pos_s5  <= pos_s4;
		end
		// s6: window-start prefix from the chain
		if (rdy6) begin
			old_s6  <= tap_out;
			hnew_s6 <= hnew_s5;
			tgt_s6  <= tgt_s5;
			win_s6  <= win_s5;
			pos_s6  <= pos_s5;
		end
		// s7: compare and output register
		if (rdy7) begin
			found_s7 <= win_s6 && (wsum == tgt_s6);
			pos_s7   <= win_s6 ? pos_s6 : '0;
		end
	end

	rhpm_history #(
		.DEPTH(MAX_PATTERN)
	) u_history (
		.clk    (clk),
		.shift  (load5),
		.hold_in(hold),
		.tap_sel(tap_sel),
		.tap_out(tap_out)
	);

	assign m_tvalid = v_s7;
	assign m_tdata  = pos_s7;
	assign m_tuser  = found_s7;

	// a new text restarts the byte count and the power of the base
	`RHPM_ASSERT_NEXT(a_start_count, clk, arst_n, accept && s_tuser, cnt_q == PW'(1))
	`RHPM_ASSERT_NEXT(a_start_power, clk, arst_n, accept && s_tuser, pow_q == rhpm_pkg::HASH_BASE)
	// an empty output register never stalls the input side
	`RHPM_ASSERT_NOW(a_empty_ready, clk, arst_n, !m_tvalid, s_tready)

endmodule

// ===== sim/rolling_hash_pattern_matcher_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the rolling hash pattern matcher: directed and random byte streams.
module rolling_hash_pattern_matcher_tb;

	localparam longint unsigned MODULUS   = 64'd1000000009;
	localparam longint unsigned BASE      = 64'd31;
	localparam longint unsigned OFFSET    = 64'd96;
	localparam int              WINDOW_MAX = 64;
	localparam int              IDLE_LIMIT = 1000;
	localparam int              ITEM_GOAL  = 700;

	typedef struct packed {
		logic        found;
		logic [31:0] pos;
	} match_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              s_tvalid = 1'b0;
	logic                              s_tready;
	logic [rhpm_pkg::BYTE_W-1:0]       s_tdata = '0;
	logic                              s_tuser = 1'b0;
	logic                              m_tvalid;
	logic                              m_tready = 1'b0;
	logic [rhpm_pkg::POS_W-1:0]        m_tdata;
	logic                              m_tuser;
	logic                              cfg_we = 1'b0;
	rhpm_pkg::reg_index_t              cfg_index = rhpm_pkg::REG_PATTERN_HASH;
	logic [rhpm_pkg::HASH_W-1:0]       cfg_data = '0;

	// expected results, oldest first
	match_t pending_matches[$];
	int     errors = 0;
	int     bytes_sent = 0;
	int     burst_left = 0;
	int     idle_cycles = 0;

	// shadow of the matcher state
	logic [29:0] pat_hash;
	logic [6:0]  pat_len;
	logic [29:0] run_hash;
	logic [29:0] run_power;
	logic [29:0] run_target;
	logic [29:0] hist_ring [WINDOW_MAX];
	logic [31:0] pos_count;
	int          ring_slot;
	int          fill_count;

	rolling_hash_pattern_matcher uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // [7:0] text_byte
		.s_tuser   (s_tuser),   // [0] text_start
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // [31:0] match_position
		.m_tuser   (m_tuser),   // [0] match_found
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// modular helpers
	function automatic logic [29:0] mod_mul(input logic [29:0] a, input logic [29:0] b);
		longint unsigned p;
		p = (longint'(a) * longint'(b)) % MODULUS;
		return p[29:0];
	endfunction

	function automatic logic [29:0] char_code(input logic [7:0] b);
		longint unsigned c;
		c = (b >= OFFSET) ? (longint'(b) - OFFSET) : (longint'(b) + MODULUS - OFFSET);
		return c[29:0];
	endfunction

	function automatic logic [29:0] hash_of(input logic [7:0] bytes[$]);
		longint unsigned acc;
		logic [29:0]     pw;
		acc = 0;
		pw = 30'd1;
		foreach (bytes[k]) begin
			acc = (acc + mod_mul(char_code(bytes[k]), pw)) % MODULUS;
			pw = mod_mul(pw, 30'd31);
		end
		return acc[29:0];
	endfunction

	function automatic int clamp_len(input int len_reg);
		if (len_reg == 0)
			return 1;
		if (len_reg > WINDOW_MAX)
			return WINDOW_MAX;
		return len_reg;
	endfunction

	function automatic void shadow_reset();
		pat_hash = '0;
		pat_len = 7'd1;
		run_hash = '0;
		run_power = 30'd1;
		run_target = '0;
		foreach (hist_ring[k])
			hist_ring[k] = '0;
		pos_count = '0;
		ring_slot = 0;
		fill_count = 0;
	endfunction

	// next result of the matcher for one accepted byte
	function automatic match_t predict_match(input logic [7:0] b, input logic st);
		match_t          res;
		int              len;
		int              old_slot;
		logic [31:0]     n;
		longint unsigned sum;
		longint unsigned win;
		res = '0;
		len = clamp_len(pat_len);
		if (st) begin
			run_hash = '0;
			run_power = 30'd1;
			pos_count = '0;
			ring_slot = 0;
			fill_count = 0;
			run_target = pat_hash;
		end
		n = pos_count;
		hist_ring[ring_slot] = run_hash;
		sum = (longint'(run_hash) + mod_mul(char_code(b), run_power)) % MODULUS;
		run_hash = sum[29:0];
		run_power = mod_mul(run_power, 30'd31);
		if (fill_count < WINDOW_MAX)
			fill_count++;
		if (fill_count >= len) begin
			old_slot = (ring_slot + WINDOW_MAX - (len - 1)) % WINDOW_MAX;
			win = (longint'(run_hash) + MODULUS - hist_ring[old_slot]) % MODULUS;
			res.found = (win[29:0] == run_target);
			res.pos = n + 32'd1 - 32'(len);
			run_target = mod_mul(run_target, 30'd31);
		end
		ring_slot = (ring_slot + 1) % WINDOW_MAX;
		pos_count = n + 32'd1;
		return res;
	endfunction

	// one byte transaction, with bursts and random gaps in between
	task automatic send_byte(input logic [7:0] b, input logic st);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5: gap = 0;
				6:                gap = $urandom_range(10, 20);
				default:          gap = $urandom_range(1, 8);
			endcase
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= st;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_matches = {pending_matches, predict_match(b, st)};
		bytes_sent++;
		burst_left--;
	endtask

	task automatic send_text(input logic [7:0] bytes[$], input bit with_start);
		foreach (bytes[k])
			send_byte(bytes[k], with_start && (k == 0));
	endtask

	// hold the sender until every result is back, then let the pipeline settle
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_matches.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// one register write, then a quiet cycle before anything else is driven
	task automatic write_reg(input rhpm_pkg::reg_index_t idx, input logic [29:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == rhpm_pkg::REG_PATTERN_HASH) begin
			pat_hash = (longint'(val) >= MODULUS) ? 30'(longint'(val) - MODULUS) : val;
			if (pos_count == 0)
				run_target = pat_hash;
		end else begin
			pat_len = val[6:0];
		end
		@(posedge clk);
	endtask

	// hash written before any byte loads the target; stream has no text_start at all
	task automatic test_load_before_text();
		logic [7:0] pat[$];
		pat = '{8'h61};
		write_reg(rhpm_pkg::REG_PATTERN_HASH, hash_of(pat));
		send_text('{8'h61, 8'h62, 8'h61}, 1'b0);
		wait_drained();
	endtask

	// smallest and largest byte values, plus the offset itself
	task automatic test_byte_extremes();
		logic [7:0] pat[$];
		pat = '{8'h00, 8'hFF};
		write_reg(rhpm_pkg::REG_PATTERN_LENGTH, 30'd2);
		write_reg(rhpm_pkg::REG_PATTERN_HASH, hash_of(pat));
		send_text('{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h60, 8'h61}, 1'b1);
		wait_drained();
	endtask

	// zero length acts as one
	task automatic test_zero_length();
		logic [7:0] pat[$];
		pat = '{8'h7A};
		write_reg(rhpm_pkg::REG_PATTERN_LENGTH, 30'd0);
		write_reg(rhpm_pkg::REG_PATTERN_HASH, hash_of(pat));
		send_text('{8'h7A, 8'h79, 8'h7A}, 1'b1);
		wait_drained();
	endtask

	// hash values at or above the modulus are folded on write
	task automatic test_hash_reduction();
		write_reg(rhpm_pkg::REG_PATTERN_LENGTH, 30'd1);
		write_reg(rhpm_pkg::REG_PATTERN_HASH, 30'd1000000009);
		send_text('{8'h60, 8'h60, 8'h61}, 1'b1);
		wait_drained();
		write_reg(rhpm_pkg::REG_PATTERN_HASH, 30'h3FFFFFFF);
		send_text('{8'h55, 8'hAA}, 1'b1);
		wait_drained();
	endtask

	// length change while a text is still running
	task automatic test_mid_text_change();
		logic [7:0] pat[$];
		pat = '{8'h61, 8'h62, 8'h63};
		write_reg(rhpm_pkg::REG_PATTERN_LENGTH, 30'd3);
		write_reg(rhpm_pkg::REG_PATTERN_HASH, hash_of(pat));
		send_text('{8'h61, 8'h62, 8'h63, 8'h61, 8'h62}, 1'b1);
		wait_drained();
		write_reg(rhpm_pkg::REG_PATTERN_LENGTH, 30'd2);
		send_text('{8'h63, 8'h61, 8'h62, 8'h63}, 1'b0);
		wait_drained();
	endtask

	// one setting: load a pattern, then texts with the pattern planted in them
	task automatic run_phase(input int len_reg, input bit wide, input bit carry_on);
		logic [7:0]  pat[$];
		logic [7:0]  text_buf[$];
		logic [29:0] hv;
		int          eff;
		int          tlen;
		int          at;
		int          n_texts;
		bit          st;
		eff = clamp_len(len_reg);
		pat.delete();
		repeat (eff)
			pat = {pat, (wide ? 8'($urandom_range(0, 255)) : 8'($urandom_range(97, 100)))};
		hv = hash_of(pat);
		case ($urandom_range(0, 7))
			0:       hv = 30'($urandom);
			1:       if (longint'(hv) + MODULUS < 64'h40000000) hv = 30'(longint'(hv) + MODULUS);
			default: ;
		endcase
		wait_drained();
		write_reg(rhpm_pkg::REG_PATTERN_LENGTH, 30'(len_reg));
		write_reg(rhpm_pkg::REG_PATTERN_HASH, hv);
		n_texts = $urandom_range(1, 3);
		for (int t = 0; t < n_texts; t++) begin
			tlen = eff + $urandom_range(0, (eff > 16) ? 20 : 30);
			text_buf.delete();
			repeat (tlen)
				text_buf = {text_buf, ((wide || $urandom_range(0, 9) == 0) ?
					8'($urandom_range(0, 255)) : 8'($urandom_range(97, 100)))};
			repeat ($urandom_range(0, 2)) begin
				at = $urandom_range(0, tlen - eff);
				foreach (pat[k])
					text_buf[at + k] = pat[k];
			end
			// broken copy of the pattern now and then
			if ($urandom_range(0, 4) == 0)
				text_buf[$urandom_range(0, tlen - 1)] = 8'($urandom_range(0, 255));
			foreach (text_buf[k]) begin
				st = (k == 0) && !(carry_on && t == 0);
				if ($urandom_range(0, 59) == 0)
					st = 1'b1;
				send_byte(text_buf[k], st);
			end
		end
	endtask

	task automatic test_random_stream();
		int phase;
		int len_reg;
		phase = 0;
		while (bytes_sent < ITEM_GOAL) begin
			case (phase)
				0: len_reg = 64;
				1: len_reg = 127;
				2: len_reg = 65;
				3: len_reg = 0;
				default:
					case ($urandom_range(0, 9))
						0:       len_reg = $urandom_range(9, 63);
						1:       len_reg = $urandom_range(64, 127);
						2:       len_reg = 0;
						default: len_reg = $urandom_range(1, 8);
					endcase
			endcase
			run_phase(len_reg, $urandom_range(0, 3) == 0, phase % 5 == 4);
			phase++;
		end
		wait_drained();
	endtask

	// receiver: switches between always ready, random stalls and long stalls
	always @(posedge clk) begin : rx_pattern
		int mode;
		int mode_left;
		int hold;
		if (mode_left == 0) begin
			mode = $urandom_range(0, 2);
			mode_left = $urandom_range(50, 300);
		end else begin
			mode_left--;
		end
		if (hold > 0) begin
			m_tready <= 1'b0;
			hold--;
		end else begin
			case (mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				default:
					if ($urandom_range(0, 15) == 0) begin
						m_tready <= 1'b0;
						hold = $urandom_range(1, 30);
					end else begin
						m_tready <= 1'b1;
					end
			endcase
		end
	end

	// compare each result transaction with the oldest expectation
	always @(posedge clk) begin : check_results
		match_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_matches.size() == 0) begin
				$error("unexpected result: match_found %0b match_position %0d", m_tuser, m_tdata);
				errors++;
			end else begin
				want = pending_matches.pop_front();
				if (m_tuser !== want.found) begin
					$error("match_found: expected %0b, got %0b", want.found, m_tuser);
					errors++;
				end
				if (m_tdata !== want.pos) begin
					$error("match_position: expected %0d, got %0d", want.pos, m_tdata);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		shadow_reset();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_load_before_text();
		test_byte_extremes();
		test_zero_length();
		test_hash_reduction();
		test_mid_text_change();
		test_random_stream();
		repeat (20) @(posedge clk);
		if (pending_matches.size() != 0) begin
			$error("%0d expected results never arrived", pending_matches.size());
			errors++;
		end
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
